@@ rtl/core/lmfd_pkg.sv @@
// Shared types, constants and the quarter-wave sine helper for the vibrato delay.
`default_nettype none
package lmfd_pkg;

  localparam int unsigned PHASE_W    = 24;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned SWEEP_W    = 20;
  localparam int unsigned LFO_W      = 17;
  localparam int unsigned WGT_W      = 26;
  localparam int unsigned LEN_CFG_W  = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  typedef enum logic [2:0] {
    WAVE_TRI,
    WAVE_SQUARE,
    WAVE_SAW,
    WAVE_INV_SAW,
    WAVE_SINE
  } wave_e;

  typedef enum logic [1:0] {
    INTERP_NEAREST,
    INTERP_LINEAR,
    INTERP_QUAD,
    INTERP_CUBIC
  } interp_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP,
    CFG_SWEEP_WIDTH,
    CFG_WAVEFORM,
    CFG_INTERP,
    CFG_DELAY_LENGTH
  } cfg_reg_e;

  typedef struct packed {
    logic [STEP_W-1:0]    phase_step;
    logic [SWEEP_W-1:0]   sweep_width;
    logic [2:0]           waveform;
    logic [1:0]           interp;
    logic [LEN_CFG_W-1:0] delay_length;
  } cfg_t;

  // |sin(r*pi/2)|, r and result in Q.30; Taylor series through x^13
  function automatic logic [30:0] quarter_sine(input logic [63:0] r);
    logic [63:0]        x;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    x   = (r * HALF_PI_Q30) >> 30;
    mag = x;
    sum = $signed(x);
    mag = (mag * x) >> 30;
    mag = (mag * x) >> 30;
    mag = mag / 64'd6;
    sum = sum - $signed(mag);
    mag = (mag * x) >> 30;
    mag = (mag * x) >> 30;
    mag = mag / 64'd20;
    sum = sum + $signed(mag);
    mag = (mag * x) >> 30;
    mag = (mag * x) >> 30;
    mag = mag / 64'd42;
    sum = sum - $signed(mag);
    mag = (mag * x) >> 30;
    mag = (mag * x) >> 30;
    mag = mag / 64'd72;
    sum = sum + $signed(mag);
    mag = (mag * x) >> 30;
    mag = (mag * x) >> 30;
    mag = mag / 64'd110;
    sum = sum - $signed(mag);
    mag = (mag * x) >> 30;
    mag = (mag * x) >> 30;
    mag = mag / 64'd156;
    sum = sum + $signed(mag);
    if (sum < 0) sum = 0;
    if (sum > $signed(ONE_Q30)) sum = $signed(ONE_Q30);
    return sum[30:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/lmfd_queue.sv @@
// Two-entry queue between the position front end and the interpolating back end.
`default_nettype none
module lmfd_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = slot_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lmfd_front.sv @@
// Front end: LFO, delay, read position, tap indexes and interpolation weights.
`default_nettype none
module lmfd_front import lmfd_pkg::*; #(
  parameter int unsigned DELAY_DEPTH      = 4096,
  parameter int unsigned SAMPLE_BITS      = 24,
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  localparam int unsigned PTR_W   = $clog2(DELAY_DEPTH),
  localparam int unsigned ENTRY_W = 2 * SAMPLE_BITS + 5 * PTR_W + 4 * WGT_W
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cfg_t                   cfg_i,
  input  wire logic                   clearing_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0] in_left_i,
  input  wire logic [SAMPLE_BITS-1:0] in_right_i,
  output logic                        push_valid_o,
  input  wire logic                   push_ready_i,
  output logic [ENTRY_W-1:0]          push_data_o
);

  localparam int unsigned LEN_W  = $clog2(DELAY_DEPTH + 1);
  localparam int unsigned POS_W  = LEN_W + 17;
  localparam int unsigned SIDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned PROD_W = SWEEP_W + LFO_W;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]  right;
    logic [SAMPLE_BITS-1:0]  left;
    logic [PTR_W-1:0]        wp;
    logic [3:0][PTR_W-1:0]   tap;
    logic [3:0][WGT_W-1:0]   wgt;
  } entry_t;

  typedef logic [LFO_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

  function automatic sine_rom_t build_sine();
    sine_rom_t   rom;
    logic [63:0] f32;
    logic [63:0] r;
    logic [1:0]  quad;
    logic [30:0] s;
    logic [16:0] q15;
    for (int unsigned i = 0; i < SINE_TABLE_DEPTH; i++) begin
      f32  = (64'(i) << 32) / SINE_TABLE_DEPTH;
      quad = f32[31:30];
      r    = {34'd0, f32[29:0]};
      if (quad[0]) r = ONE_Q30 - r;
      s    = quarter_sine(r);
      q15  = 17'((64'(s) + 64'd16384) >> 15);
      rom[i] = quad[1] ? (17'd32768 - q15) : (17'd32768 + q15);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_POS, F_WRAP, F_SQR, F_CUBE, F_WGT, F_PUSH
  } fstate_e;

  fstate_e                 state_q;
  logic [PHASE_W-1:0]      phase_q;
  logic [PTR_W-1:0]        wp_q;
  logic [LEN_W-1:0]        len_q;
  logic [SAMPLE_BITS-1:0]  left_q, right_q;
  logic [LFO_W-1:0]        sine_q;
  logic [PROD_W-1:0]       prod_q;
  logic [POS_W-1:0]        pos_q;
  logic [31:0]             sq_q;
  logic [47:0]             cube_q;
  logic [15:0]             frac_q;
  logic [3:0][PTR_W-1:0]   tap_q;
  logic [3:0][WGT_W-1:0]   wgt_q;

  logic [LEN_W-1:0]        len_c;
  logic [SIDX_W-1:0]       sidx_c;
  logic [15:0]             q_c;
  logic [LFO_W-1:0]        lfo_c;
  logic [28:0]             d_c;
  logic [POS_W-1:0]        dmax_c, dcl_c, base_c, span_c;
  logic [LEN_W:0]          iw_c, nw_c, cw_c, t2w_c, lenw_c;
  logic [15:0]             f_c;
  logic signed [31:0]      fsq_c;
  logic [3:0][PTR_W-1:0]   tap_c;
  logic signed [40:0]      qf2_c, qfs_c;
  logic signed [55:0]      c1_c, c2_c, c3_c;
  logic [3:0][WGT_W-1:0]   wgt_c;
  entry_t                  ent_c;

  localparam logic signed [40:0] QR = 41'sd256;
  localparam logic signed [55:0] CR = 56'sd16777216;

  always_comb begin
    if (cfg_i.delay_length < 13'd4) len_c = LEN_W'(4);
    else if (32'(cfg_i.delay_length) > DELAY_DEPTH) len_c = LEN_W'(DELAY_DEPTH);
    else len_c = LEN_W'(cfg_i.delay_length);
  end

  assign sidx_c = SIDX_W'((64'(phase_q) * SINE_TABLE_DEPTH) >> 24);

  always_ff @(posedge clk_i) begin
    sine_q <= SINE_ROM[sidx_c];
  end

  // unipolar LFO in Q.16
  always_comb begin
    q_c = phase_q[23:8];
    unique case (cfg_i.waveform)
      WAVE_TRI: begin
        if (q_c < 16'h4000)      lfo_c = 17'd32768 + {q_c, 1'b0};
        else if (q_c < 16'hC000) lfo_c = 17'd65536 - {q_c - 16'h4000, 1'b0};
        else                     lfo_c = {q_c - 16'hC000, 1'b0};
      end
      WAVE_SQUARE:  lfo_c = q_c[15] ? 17'd0 : 17'd65536;
      WAVE_SAW:     lfo_c = q_c[15] ? ({1'b0, q_c} - 17'd32768) : ({1'b0, q_c} + 17'd32768);
      WAVE_INV_SAW: lfo_c = q_c[15] ? (17'd98304 - {1'b0, q_c}) : (17'd32768 - {1'b0, q_c});
      default:      lfo_c = sine_q;
    endcase
  end

  always_comb begin
    d_c    = prod_q[PROD_W-1:8];
    dmax_c = POS_W'({len_q - LEN_W'(3), 16'h0});
    dcl_c  = (POS_W'(d_c) > dmax_c) ? dmax_c : POS_W'(d_c);
    base_c = POS_W'({(LEN_W+1)'(wp_q) + (LEN_W+1)'(len_q) - (LEN_W+1)'(3), 16'h0});
    span_c = POS_W'({len_q, 16'h0});
  end

  // tap indexes from the wrapped position
  always_comb begin
    lenw_c = (LEN_W+1)'(len_q);
    iw_c   = (LEN_W+1)'(pos_q >> 16);
    f_c    = pos_q[15:0];
    nw_c   = iw_c + (LEN_W+1)'(f_c[15]);
    fsq_c  = $signed(f_c) * $signed(f_c);
    cw_c   = (nw_c >= lenw_c) ? '0 : nw_c;
    t2w_c  = (iw_c + 1'b1 >= lenw_c) ? (iw_c + 1'b1 - lenw_c) : (iw_c + 1'b1);
    for (int k = 0; k < 4; k++) tap_c[k] = PTR_W'(iw_c);
    unique case (cfg_i.interp)
      INTERP_NEAREST: tap_c[0] = PTR_W'(cw_c);
      INTERP_LINEAR:  tap_c[1] = (iw_c + 1'b1 >= lenw_c) ? '0 : PTR_W'(iw_c + 1'b1);
      INTERP_QUAD: begin
        tap_c[0] = (cw_c == '0) ? PTR_W'(lenw_c - 1'b1) : PTR_W'(cw_c - 1'b1);
        tap_c[1] = PTR_W'(cw_c);
        tap_c[2] = (cw_c + 1'b1 >= lenw_c) ? '0 : PTR_W'(cw_c + 1'b1);
      end
      default: begin
        tap_c[0] = (iw_c == '0) ? PTR_W'(lenw_c - 1'b1) : PTR_W'(iw_c - 1'b1);
        tap_c[2] = PTR_W'(t2w_c);
        tap_c[3] = (t2w_c + 1'b1 >= lenw_c) ? '0 : PTR_W'(t2w_c + 1'b1);
      end
    endcase
  end

  // weights in Q.24
  always_comb begin
    qf2_c = $signed({9'd0, sq_q});
    qfs_c = 41'($signed(frac_q)) <<< 16;
    c1_c  = $signed({8'd0, frac_q, 32'd0});
    c2_c  = $signed({8'd0, sq_q, 16'd0});
    c3_c  = $signed({8'd0, cube_q});
    wgt_c = '0;
    unique case (cfg_i.interp)
      INTERP_NEAREST: wgt_c[0] = WGT_W'(32'd16777216);
      INTERP_LINEAR: begin
        wgt_c[0] = WGT_W'({17'd65536 - {1'b0, frac_q}, 8'd0});
        wgt_c[1] = WGT_W'({frac_q, 8'd0});
      end
      INTERP_QUAD: begin
        wgt_c[0] = WGT_W'((qf2_c - qfs_c + QR) >>> 9);
        wgt_c[1] = WGT_W'(((41'sd1 <<< 33) - 41'sd2 * qf2_c + QR) >>> 9);
        wgt_c[2] = WGT_W'((qf2_c + qfs_c + QR) >>> 9);
      end
      default: begin
        wgt_c[0] = WGT_W'((-c3_c + 56'sd2 * c2_c - c1_c + CR) >>> 25);
        wgt_c[1] = WGT_W'((56'sd3 * c3_c - 56'sd5 * c2_c + (56'sd1 <<< 49) + CR) >>> 25);
        wgt_c[2] = WGT_W'((-(56'sd3 * c3_c) + 56'sd4 * c2_c + c1_c + CR) >>> 25);
        wgt_c[3] = WGT_W'((c3_c - c2_c + CR) >>> 25);
      end
    endcase
  end

  always_comb begin
    ent_c.right = right_q;
    ent_c.left  = left_q;
    ent_c.wp    = wp_q;
    ent_c.tap   = tap_q;
    ent_c.wgt   = wgt_q;
  end

  assign in_ready_o   = (state_q == F_IDLE) && !clearing_i;
  assign push_valid_o = (state_q == F_PUSH);
  assign push_data_o  = ent_c;

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      F_IDLE: begin
        left_q  <= in_left_i;
        right_q <= in_right_i;
      end
      F_MUL:  prod_q <= PROD_W'(cfg_i.sweep_width) * PROD_W'(lfo_c);
      F_POS:  pos_q  <= base_c - dcl_c;
      F_WRAP: if (pos_q >= span_c) pos_q <= pos_q - span_c;
      F_SQR: begin
        tap_q  <= tap_c;
        frac_q <= f_c;
        sq_q   <= (cfg_i.interp == INTERP_QUAD) ? fsq_c : (32'(f_c) * 32'(f_c));
      end
      F_CUBE: cube_q <= 48'(sq_q) * 48'(frac_q);
      F_WGT:  wgt_q  <= wgt_c;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      phase_q <= '0;
      wp_q    <= '0;
      len_q   <= LEN_W'(4);
    end else begin
      unique case (state_q)
        F_IDLE: if (in_valid_i && in_ready_o) begin
          len_q   <= len_c;
          if ((LEN_W+1)'(wp_q) >= (LEN_W+1)'(len_c)) wp_q <= '0;
          state_q <= F_MUL;
        end
        F_MUL:  state_q <= F_POS;
        F_POS:  state_q <= F_WRAP;
        F_WRAP: state_q <= F_SQR;
        F_SQR:  state_q <= F_CUBE;
        F_CUBE: state_q <= F_WGT;
        F_WGT:  state_q <= F_PUSH;
        F_PUSH: if (push_ready_i) begin
          if ((LEN_W+1)'(wp_q) + 1'b1 >= (LEN_W+1)'(len_q)) wp_q <= '0;
          else wp_q <= wp_q + 1'b1;
          phase_q <= phase_q + PHASE_W'(cfg_i.phase_step);
          state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lmfd_back.sv @@
// Back end: delay store, clearing pass, four-tap MAC per channel and output register.
`default_nettype none
module lmfd_back import lmfd_pkg::*; #(
  parameter int unsigned DELAY_DEPTH = 4096,
  parameter int unsigned SAMPLE_BITS = 24,
  localparam int unsigned PTR_W   = $clog2(DELAY_DEPTH),
  localparam int unsigned ENTRY_W = 2 * SAMPLE_BITS + 5 * PTR_W + 4 * WGT_W
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  output logic                        clearing_o,
  input  wire logic                   pop_valid_i,
  output logic                        pop_ready_o,
  input  wire logic [ENTRY_W-1:0]     pop_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0]      out_left_o,
  output logic [SAMPLE_BITS-1:0]      out_right_o
);

  localparam int unsigned PR_W  = SAMPLE_BITS + WGT_W;
  localparam int unsigned ACC_W = PR_W + 2;
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - 1;
  localparam logic signed [ACC_W-1:0] RHALF = ACC_W'(64'd8388608);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]  right;
    logic [SAMPLE_BITS-1:0]  left;
    logic [PTR_W-1:0]        wp;
    logic [3:0][PTR_W-1:0]   tap;
    logic [3:0][WGT_W-1:0]   wgt;
  } entry_t;

  typedef enum logic [2:0] {B_CLR, B_IDLE, B_RD, B_MUL, B_ACC, B_FIN} bstate_e;

  function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] y;
    y = (a + RHALF) >>> 24;
    if (y > SMAX) return SMAX[SAMPLE_BITS-1:0];
    if (y < SMIN) return SMIN[SAMPLE_BITS-1:0];
    return y[SAMPLE_BITS-1:0];
  endfunction

  logic [2*SAMPLE_BITS-1:0] mem [DELAY_DEPTH];

  bstate_e                   state_q;
  entry_t                    ent_q;
  logic [1:0]                k_q;
  logic [PTR_W-1:0]          clr_q;
  logic [2*SAMPLE_BITS-1:0]  rd_q;
  logic signed [PR_W-1:0]    pl_q, pr_q;
  logic signed [ACC_W-1:0]   al_q, ar_q;
  logic                      out_valid_q;
  logic [SAMPLE_BITS-1:0]    out_left_q, out_right_q;

  logic                      out_free;
  logic                      mem_we;
  logic [PTR_W-1:0]          mem_wa;
  logic [2*SAMPLE_BITS-1:0]  mem_wd;

  assign out_free    = !out_valid_q || out_ready_i;
  assign clearing_o  = (state_q == B_CLR);
  assign pop_ready_o = (state_q == B_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_left_q;
  assign out_right_o = out_right_q;

  assign mem_we = (state_q == B_CLR) || ((state_q == B_FIN) && out_free);
  assign mem_wa = (state_q == B_CLR) ? clr_q : ent_q.wp;
  assign mem_wd = (state_q == B_CLR) ? '0 : {ent_q.right, ent_q.left};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[ent_q.tap[k_q]];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: if (pop_valid_i) ent_q <= pop_data_i;
      B_MUL: begin
        pl_q <= $signed(rd_q[SAMPLE_BITS-1:0]) * $signed(ent_q.wgt[k_q]);
        pr_q <= $signed(rd_q[2*SAMPLE_BITS-1:SAMPLE_BITS]) * $signed(ent_q.wgt[k_q]);
      end
      B_FIN: if (out_free) begin
        out_left_q  <= round_sat(al_q);
        out_right_q <= round_sat(ar_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      clr_q       <= '0;
      k_q         <= '0;
      al_q        <= '0;
      ar_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result may replace the one leaving in the same cycle
      if ((state_q == B_FIN) && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)               out_valid_q <= 1'b0;
      unique case (state_q)
        B_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == PTR_W'(DELAY_DEPTH - 1)) state_q <= B_IDLE;
        end
        B_IDLE: if (pop_valid_i) begin
          k_q     <= '0;
          al_q    <= '0;
          ar_q    <= '0;
          state_q <= B_RD;
        end
        B_RD:  state_q <= B_MUL;
        B_MUL: state_q <= B_ACC;
        B_ACC: begin
          al_q    <= al_q + ACC_W'(pl_q);
          ar_q    <= ar_q + ACC_W'(pr_q);
          k_q     <= k_q + 2'd1;
          state_q <= (k_q == 2'd3) ? B_FIN : B_RD;
        end
        B_FIN: if (out_free) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lfo_modulated_fractional_delay.sv @@
// Top level of the LFO-swept stereo fractional delay (vibrato).
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata: left_sample, right_sample
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata: left_out, right_out
//   cfg       in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// Front end steps each frame through LFO, delay, position and weights, one frame at a time;
// back end reads, multiplies and accumulates four taps in turn on the single store read port.
// The two-entry queue between them lets the front end take a new frame while the back end works.
// After reset a clearing pass zeroes every store entry, with s_axis_tready held low.
// A stalled output holds in its register while the next frame is already taken in.
`default_nettype none
module lfo_modulated_fractional_delay import lmfd_pkg::*; #(
  parameter int unsigned DELAY_DEPTH      = 4096,
  parameter int unsigned SAMPLE_BITS      = 24,
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  localparam int unsigned TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [TDATA_W-1:0]    s_axis_tdata,  // left_sample, right_sample
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [TDATA_W-1:0]         m_axis_tdata,  // left_out, right_out
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned PTR_W   = $clog2(DELAY_DEPTH);
  localparam int unsigned ENTRY_W = 2 * SAMPLE_BITS + 5 * PTR_W + 4 * WGT_W;

  cfg_t                   cfg_q;
  logic                   clearing;
  logic                   push_valid, push_ready, pop_valid, pop_ready;
  logic [ENTRY_W-1:0]     push_data, pop_data;
  logic [SAMPLE_BITS-1:0] out_left, out_right;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_step   <= 16'd350;
      cfg_q.sweep_width  <= 20'd122880;
      cfg_q.waveform     <= WAVE_SQUARE;
      cfg_q.interp       <= INTERP_LINEAR;
      cfg_q.delay_length <= 13'd2403;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PHASE_STEP:   cfg_q.phase_step   <= cfg_data_i[STEP_W-1:0];
        CFG_SWEEP_WIDTH:  cfg_q.sweep_width  <= cfg_data_i[SWEEP_W-1:0];
        CFG_WAVEFORM:     cfg_q.waveform     <= cfg_data_i[2:0];
        CFG_INTERP:       cfg_q.interp       <= cfg_data_i[1:0];
        CFG_DELAY_LENGTH: cfg_q.delay_length <= cfg_data_i[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  lmfd_front #(
    .DELAY_DEPTH      (DELAY_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .clearing_i   (clearing),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_left_i    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_right_i   (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  lmfd_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  lmfd_back #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clearing_o  (clearing),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_left_o  (out_left),
    .out_right_o (out_right)
  );

  assign m_axis_tdata = TDATA_W'({out_right, out_left});

  // no frame enters while the store is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_axis_tready)
    else $error("input taken during clearing pass");

  // front end works one frame at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("front end ready straight after a transfer");

  // the clearing pass runs once after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clearing |=> !clearing)
    else $error("clearing pass restarted");

endmodule
`default_nettype wire
